// File: rtl/core/rclpg_pkg.sv
// rclpg_pkg: shared types, codes and constants of the rc link packet and hop generator
`default_nettype none

package rclpg_pkg;

    // request codes on the input channel
    localparam logic [1:0] REQ_TICK        = 2'd0;
    localparam logic [1:0] REQ_START       = 2'd1;
    localparam logic [1:0] REQ_START_BIND  = 2'd2;

    // register indexes on the configuration port
    localparam logic [1:0] REG_RADIO_ID    = 2'd0;
    localparam logic [1:0] REG_CH_USED     = 2'd1;
    localparam logic [1:0] REG_ACC_MODE    = 2'd2;
    localparam logic [1:0] REG_BIND_TICKS  = 2'd3;

    // register reset values
    localparam logic [31:0] RADIO_ID_RST   = 32'd0;
    localparam logic [3:0]  CH_USED_RST    = 4'd8;
    localparam logic        ACC_MODE_RST   = 1'b0;
    localparam logic [15:0] BIND_TICKS_RST = 16'd2500;

    // packet layout
    localparam int          PKT_LEN        = 21;
    localparam int          NUM_CH         = 8;
    localparam logic [4:0]  LAST_IDX       = 5'd20;
    localparam logic [7:0]  TYPE_BIND      = 8'hAA;
    localparam logic [7:0]  TYPE_NORMAL    = 8'h55;

    // pulse width scaling, microseconds
    localparam logic [23:0] PW_GAIN        = 24'd500;
    localparam logic [11:0] PW_CENTER      = 12'd1500;
    localparam logic [11:0] PW_MIN         = 12'd900;
    localparam logic [11:0] PW_MAX         = 12'd2100;
    localparam logic [23:0] PW_SPAN        = 24'd600;
    localparam int          RECIP_SHIFT    = 24;

    // accessory flag bits
    localparam logic [7:0]  ACC_CH4_FLAG   = 8'h20;
    localparam logic [7:0]  ACC_CH5_FLAG   = 8'h40;
    localparam logic [7:0]  ACC_CH6_FLAG   = 8'h80;
    localparam logic [7:0]  ACC_CH7_FLAG   = 8'h10;

    // hop selection
    localparam logic [7:0]  BIND_RF        = 8'd1;
    localparam logic [3:0]  HOP_OFFS_MAX   = 4'd9;

    localparam logic [7:0] HOP_TABLE [16][16] = '{
        '{8'd10,  8'd90,  8'd20,  8'd100, 8'd30,  8'd110, 8'd40,  8'd120,
          8'd50,  8'd130, 8'd60,  8'd140, 8'd70,  8'd150, 8'd80,  8'd160},
        '{8'd160, 8'd80,  8'd150, 8'd70,  8'd140, 8'd60,  8'd130, 8'd50,
          8'd120, 8'd40,  8'd110, 8'd30,  8'd100, 8'd20,  8'd90,  8'd10},
        '{8'd10,  8'd90,  8'd80,  8'd160, 8'd20,  8'd100, 8'd70,  8'd150,
          8'd30,  8'd110, 8'd60,  8'd140, 8'd40,  8'd120, 8'd50,  8'd130},
        '{8'd130, 8'd50,  8'd120, 8'd40,  8'd140, 8'd60,  8'd110, 8'd30,
          8'd150, 8'd70,  8'd100, 8'd20,  8'd160, 8'd80,  8'd90,  8'd10},
        '{8'd40,  8'd120, 8'd10,  8'd90,  8'd80,  8'd160, 8'd20,  8'd100,
          8'd30,  8'd110, 8'd60,  8'd140, 8'd50,  8'd130, 8'd70,  8'd150},
        '{8'd150, 8'd70,  8'd130, 8'd50,  8'd140, 8'd60,  8'd110, 8'd30,
          8'd100, 8'd20,  8'd160, 8'd80,  8'd90,  8'd10,  8'd120, 8'd40},
        '{8'd80,  8'd160, 8'd40,  8'd120, 8'd10,  8'd90,  8'd30,  8'd110,
          8'd60,  8'd140, 8'd50,  8'd130, 8'd70,  8'd150, 8'd20,  8'd100},
        '{8'd100, 8'd20,  8'd150, 8'd70,  8'd130, 8'd50,  8'd140, 8'd60,
          8'd110, 8'd30,  8'd90,  8'd10,  8'd120, 8'd40,  8'd160, 8'd80},
        '{8'd80,  8'd160, 8'd70,  8'd150, 8'd60,  8'd140, 8'd40,  8'd120,
          8'd10,  8'd90,  8'd50,  8'd130, 8'd30,  8'd110, 8'd20,  8'd100},
        '{8'd100, 8'd20,  8'd110, 8'd30,  8'd130, 8'd50,  8'd90,  8'd10,
          8'd120, 8'd40,  8'd140, 8'd60,  8'd150, 8'd70,  8'd160, 8'd80},
        '{8'd70,  8'd150, 8'd60,  8'd140, 8'd80,  8'd160, 8'd40,  8'd120,
          8'd10,  8'd90,  8'd30,  8'd110, 8'd50,  8'd130, 8'd20,  8'd100},
        '{8'd100, 8'd20,  8'd130, 8'd50,  8'd110, 8'd30,  8'd90,  8'd10,
          8'd120, 8'd40,  8'd160, 8'd80,  8'd140, 8'd60,  8'd150, 8'd70},
        '{8'd70,  8'd150, 8'd10,  8'd90,  8'd60,  8'd140, 8'd20,  8'd100,
          8'd80,  8'd160, 8'd40,  8'd120, 8'd30,  8'd110, 8'd50,  8'd130},
        '{8'd130, 8'd50,  8'd110, 8'd30,  8'd120, 8'd40,  8'd160, 8'd80,
          8'd100, 8'd20,  8'd140, 8'd60,  8'd90,  8'd10,  8'd150, 8'd70},
        '{8'd70,  8'd150, 8'd10,  8'd90,  8'd80,  8'd160, 8'd60,  8'd140,
          8'd40,  8'd120, 8'd30,  8'd110, 8'd50,  8'd130, 8'd20,  8'd100},
        '{8'd100, 8'd20,  8'd130, 8'd50,  8'd110, 8'd30,  8'd120, 8'd40,
          8'd140, 8'd60,  8'd160, 8'd80,  8'd90,  8'd10,  8'd150, 8'd70}
    };

    // input transfer payload
    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [15:0] ch0;
        logic signed [15:0] ch1;
        logic signed [15:0] ch2;
        logic signed [15:0] ch3;
        logic signed [15:0] ch4;
        logic signed [15:0] ch5;
        logic signed [15:0] ch6;
        logic signed [15:0] ch7;
    } in_item_t;

    // result transfer payload
    typedef struct packed {
        logic [7:0] data_byte;
        logic [4:0] byte_index;
        logic [7:0] rf_channel;
        logic       is_bind;
        logic       bind_finished;
        logic       last;
    } out_item_t;

endpackage : rclpg_pkg

`default_nettype wire

// File: rtl/core/rc_link_packet_and_hop_generator.sv
// rc_link_packet_and_hop_generator: packet builder, hop selector and byte serializer
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+------------------------------------
//  s_       | in        | s_valid / s_ready   | in_item_t: req_type, ch0..ch7
//  m_       | out       | m_valid / m_ready   | out_item_t: one packet byte + tags
//  apb      | in/out    | psel/penable/pready | radio_id, channels_used, acc mode, bind
//
//  a tick's packet leaves one byte per transfer from a 21-byte shift register
//  first byte is valid once the tick has left the last stage; starts do not wait for the shift register
//  a five-stage pulse width pipeline feeds the shift register, so the next tick is taken
//  while the current packet drains; a stalled m_ready holds the pipeline behind it
//  reset clears pipeline valids, bind countdown, hop column and loads register defaults
`default_nettype none

module rc_link_packet_and_hop_generator
    import rclpg_pkg::*;
#(
    parameter int CHANNEL_FULL_SCALE = 10000
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input channel
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_item_t    s_data,
    // result channel
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_item_t        m_data,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // divider constants: quotient estimate is low by at most one
    localparam logic [14:0] FS_W  = 15'(CHANNEL_FULL_SCALE);
    localparam logic [24:0] RECIP = 25'((64'd1 << RECIP_SHIFT) / CHANNEL_FULL_SCALE);

    // ---------------------------------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------------------------------
    logic [31:0] radio_id_reg;
    logic [3:0]  ch_used_reg;
    logic        acc_mode_reg;
    logic [15:0] bind_ticks_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // register write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radio_id_reg   <= RADIO_ID_RST;
            ch_used_reg    <= CH_USED_RST;
            acc_mode_reg   <= ACC_MODE_RST;
            bind_ticks_reg <= BIND_TICKS_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_RADIO_ID:   radio_id_reg   <= pwdata;
                REG_CH_USED:    ch_used_reg    <= pwdata[3:0];
                REG_ACC_MODE:   acc_mode_reg   <= pwdata[0];
                REG_BIND_TICKS: bind_ticks_reg <= pwdata[15:0];
                default:        ;
            endcase
        end
    end

    // register read
    always_comb begin
        unique case (paddr[3:2])
            REG_RADIO_ID:   prdata = radio_id_reg;
            REG_CH_USED:    prdata = {28'd0, ch_used_reg};
            REG_ACC_MODE:   prdata = {31'd0, acc_mode_reg};
            REG_BIND_TICKS: prdata = {16'd0, bind_ticks_reg};
            default:        prdata = 32'd0;
        endcase
    end

    // ---------------------------------------------------------------------------------------
    // pipeline control
    // ---------------------------------------------------------------------------------------
    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy0, rdy1, rdy2, rdy3, rdy4;
    logic take4;
    logic pkt_free;
    logic [1:0] req0_reg, req1_reg, req2_reg, req3_reg, req4_reg;

    // a start item leaves the last stage without waiting for the packet buffer
    assign take4 = v4_reg && ((req4_reg != REQ_TICK) || pkt_free);
    assign rdy4  = !v4_reg || take4;
    assign rdy3  = !v3_reg || rdy4;
    assign rdy2  = !v2_reg || rdy3;
    assign rdy1  = !v1_reg || rdy2;
    assign rdy0  = !v0_reg || rdy1;
    assign s_ready = rdy0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy0) v0_reg <= s_valid;
            if (rdy1) v1_reg <= v0_reg;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // ---------------------------------------------------------------------------------------
    // stage 0: input register
    // ---------------------------------------------------------------------------------------
    logic signed [15:0] ch0_reg [NUM_CH];

    always_ff @(posedge aclk) begin
        if (rdy0) begin
            req0_reg   <= s_data.req_type;
            ch0_reg[0] <= s_data.ch0;
            ch0_reg[1] <= s_data.ch1;
            ch0_reg[2] <= s_data.ch2;
            ch0_reg[3] <= s_data.ch3;
            ch0_reg[4] <= s_data.ch4;
            ch0_reg[5] <= s_data.ch5;
            ch0_reg[6] <= s_data.ch6;
            ch0_reg[7] <= s_data.ch7;
        end
    end

    // ---------------------------------------------------------------------------------------
    // stage 1: sign, magnitude and scaled magnitude per lane
    // ---------------------------------------------------------------------------------------
    logic [23:0] p1_next   [NUM_CH];
    logic [23:0] p1_reg    [NUM_CH];
    logic [23:0] p2_reg    [NUM_CH];
    logic [23:0] p3_reg    [NUM_CH];
    logic [NUM_CH-1:0] neg1_next, neg1_reg, neg2_reg, neg3_reg;
    logic [NUM_CH-1:0] pos1_next, pos1_reg, pos2_reg, pos3_reg, pos4_reg;

    always_comb begin
        logic [15:0] mag;
        for (int i = 0; i < NUM_CH; i++) begin
            neg1_next[i] = ch0_reg[i][15];
            pos1_next[i] = !ch0_reg[i][15] && (ch0_reg[i] != 16'sd0);
            mag          = ch0_reg[i][15] ? (~ch0_reg[i] + 16'd1) : ch0_reg[i];
            p1_next[i]   = 24'(mag) * PW_GAIN;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            req1_reg <= req0_reg;
            neg1_reg <= neg1_next;
            pos1_reg <= pos1_next;
            p1_reg   <= p1_next;
        end
    end

    // ---------------------------------------------------------------------------------------
    // stage 2: quotient estimate by reciprocal multiply
    // ---------------------------------------------------------------------------------------
    logic [23:0] qe2_next [NUM_CH];
    logic [23:0] qe2_reg  [NUM_CH];
    logic [23:0] qe3_reg  [NUM_CH];

    always_comb begin
        logic [48:0] prod;
        for (int i = 0; i < NUM_CH; i++) begin
            prod        = 49'(p1_reg[i]) * 49'(RECIP);
            qe2_next[i] = 24'(prod >> RECIP_SHIFT);
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            req2_reg <= req1_reg;
            neg2_reg <= neg1_reg;
            pos2_reg <= pos1_reg;
            p2_reg   <= p1_reg;
            qe2_reg  <= qe2_next;
        end
    end

    // ---------------------------------------------------------------------------------------
    // stage 3: back-multiply the estimate
    // ---------------------------------------------------------------------------------------
    logic [23:0] pe3_next [NUM_CH];
    logic [23:0] pe3_reg  [NUM_CH];

    always_comb begin
        logic [38:0] prod;
        for (int i = 0; i < NUM_CH; i++) begin
            prod        = 39'(qe2_reg[i]) * 39'(FS_W);
            pe3_next[i] = prod[23:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            req3_reg <= req2_reg;
            neg3_reg <= neg2_reg;
            pos3_reg <= pos2_reg;
            p3_reg   <= p2_reg;
            qe3_reg  <= qe2_reg;
            pe3_reg  <= pe3_next;
        end
    end

    // ---------------------------------------------------------------------------------------
    // stage 4: quotient correction, offset and clamp
    // ---------------------------------------------------------------------------------------
    logic [11:0] w4_next [NUM_CH];
    logic [11:0] w4_reg  [NUM_CH];

    always_comb begin
        logic [23:0] rem;
        logic [23:0] q;
        for (int i = 0; i < NUM_CH; i++) begin
            rem = p3_reg[i] - pe3_reg[i];
            q   = qe3_reg[i] + ((rem >= 24'(FS_W)) ? 24'd1 : 24'd0);
            if (q >= PW_SPAN) begin
                w4_next[i] = neg3_reg[i] ? PW_MIN : PW_MAX;
            end else if (neg3_reg[i]) begin
                w4_next[i] = PW_CENTER - q[11:0];
            end else begin
                w4_next[i] = PW_CENTER + q[11:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            req4_reg <= req3_reg;
            pos4_reg <= pos3_reg;
            w4_reg   <= w4_next;
        end
    end

    // ---------------------------------------------------------------------------------------
    // packet assembly, bind countdown and hop selection
    // ---------------------------------------------------------------------------------------
    logic [15:0] bind_left_reg, bind_left_next;
    logic [3:0]  hop_col_reg, hop_col_next;
    logic [7:0]  pkt_bytes [PKT_LEN];
    logic [7:0]  rf_asm;
    logic        binding;
    logic        fin_asm;
    logic [3:0]  hop_offs;

    assign binding  = (bind_left_reg != 16'd0);
    assign hop_offs = (radio_id_reg[7:4] > HOP_OFFS_MAX) ? HOP_OFFS_MAX : radio_id_reg[7:4];

    // state update on the item leaving the last stage
    always_comb begin
        bind_left_next = bind_left_reg;
        hop_col_next   = hop_col_reg;
        if (take4) begin
            case (req4_reg)
                REQ_START: begin
                    bind_left_next = 16'd0;
                    hop_col_next   = 4'd0;
                end
                REQ_START_BIND: begin
                    bind_left_next = bind_ticks_reg;
                    hop_col_next   = 4'd0;
                end
                REQ_TICK: begin
                    if (binding) bind_left_next = bind_left_reg - 16'd1;
                    else         hop_col_next   = hop_col_reg + 4'd1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bind_left_reg <= 16'd0;
            hop_col_reg   <= 4'd0;
        end else begin
            bind_left_reg <= bind_left_next;
            hop_col_reg   <= hop_col_next;
        end
    end

    // packet bytes and per-packet tags
    always_comb begin
        logic [11:0] w;
        pkt_bytes[0] = binding ? TYPE_BIND : TYPE_NORMAL;
        pkt_bytes[1] = radio_id_reg[7:0];
        pkt_bytes[2] = radio_id_reg[15:8];
        pkt_bytes[3] = radio_id_reg[23:16];
        pkt_bytes[4] = radio_id_reg[31:24];
        for (int i = 0; i < NUM_CH; i++) begin
            w = (4'(i) < ch_used_reg) ? w4_reg[i] : PW_CENTER;
            pkt_bytes[5 + 2*i] = w[7:0];
            pkt_bytes[6 + 2*i] = {4'd0, w[11:8]};
        end
        // accessory flags over the slot 2 and slot 3 high bytes
        if (acc_mode_reg) begin
            if (pos4_reg[4]) pkt_bytes[12] = pkt_bytes[12] | ACC_CH4_FLAG;
            if (pos4_reg[5]) pkt_bytes[10] = pkt_bytes[10] | ACC_CH5_FLAG;
            if (pos4_reg[6]) pkt_bytes[10] = pkt_bytes[10] | ACC_CH6_FLAG;
            if (pos4_reg[7]) pkt_bytes[12] = pkt_bytes[12] | ACC_CH7_FLAG;
        end
        rf_asm  = binding ? BIND_RF
                          : (HOP_TABLE[radio_id_reg[3:0]][hop_col_reg] - 8'(hop_offs));
        fin_asm = binding && (bind_left_reg == 16'd1);
    end

    // ---------------------------------------------------------------------------------------
    // packet shift register and byte serializer
    // ---------------------------------------------------------------------------------------
    logic [7:0] pkt_reg [PKT_LEN];
    logic [7:0] pkt_next [PKT_LEN];
    logic       pkt_valid_reg, pkt_valid_next;
    logic [4:0] idx_reg, idx_next;
    logic [7:0] rf_reg;
    logic       bind_reg;
    logic       fin_reg;
    logic       out_xfer;
    logic       out_last;
    logic       load_pkt;

    assign out_last = (idx_reg == LAST_IDX);
    assign out_xfer = pkt_valid_reg && m_ready;
    assign pkt_free = !pkt_valid_reg || (m_ready && out_last);
    assign load_pkt = take4 && (req4_reg == REQ_TICK);

    always_comb begin
        pkt_valid_next = pkt_valid_reg;
        idx_next       = idx_reg;
        for (int j = 0; j < PKT_LEN - 1; j++) pkt_next[j] = pkt_reg[j + 1];
        pkt_next[PKT_LEN - 1] = pkt_reg[PKT_LEN - 1];
        if (load_pkt) begin
            pkt_valid_next = 1'b1;
            idx_next       = 5'd0;
            pkt_next       = pkt_bytes;
        end else if (out_xfer) begin
            if (out_last) pkt_valid_next = 1'b0;
            idx_next = idx_reg + 5'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pkt_valid_reg <= 1'b0;
            idx_reg       <= 5'd0;
        end else begin
            pkt_valid_reg <= pkt_valid_next;
            idx_reg       <= idx_next;
        end
    end

    // byte shift and packet tags
    always_ff @(posedge aclk) begin
        if (load_pkt || out_xfer) pkt_reg <= pkt_next;
        if (load_pkt) begin
            rf_reg   <= rf_asm;
            bind_reg <= binding;
            fin_reg  <= fin_asm;
        end
    end

    assign m_valid              = pkt_valid_reg;
    assign m_data.data_byte     = pkt_reg[0];
    assign m_data.byte_index    = idx_reg;
    assign m_data.rf_channel    = rf_reg;
    assign m_data.is_bind       = bind_reg;
    assign m_data.bind_finished = fin_reg;
    assign m_data.last          = out_last;

    // ---------------------------------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------------------------------
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (idx_reg <= LAST_IDX))
        else $error("byte index beyond packet end");

    a_idx_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !out_last) |=> (m_valid && (idx_reg == $past(idx_reg) + 5'd1)))
        else $error("packet bytes not sent in order");

    a_bind_rf: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.is_bind) |-> (m_data.rf_channel == BIND_RF))
        else $error("bind packet not on bind channel");

    a_fin_bind: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.bind_finished) |-> m_data.is_bind)
        else $error("bind end flagged on normal packet");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        load_pkt |-> pkt_free)
        else $error("packet loaded over unsent bytes");

endmodule : rc_link_packet_and_hop_generator

`default_nettype wire

// File: bench/tb_top.sv
// tb_top: self-checking bench for the rc link packet and hop generator
`timescale 1ns / 100ps

module tb_top;
    import rclpg_pkg::*;

    localparam int FULL_SCALE   = 10000;
    localparam int SETTLE       = 40;
    localparam int MAX_PRINT    = 40;
    localparam int RAND_PHASES  = 7;
    localparam int PHASE_ITEMS  = 37;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always #5 aclk = ~aclk;

    // block ports
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_data  = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_data;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [3:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    rc_link_packet_and_hop_generator #(
        .CHANNEL_FULL_SCALE (FULL_SCALE)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // requests waiting to be sent and packet bytes still owed by the block
    in_item_t  pending_reqs [$];
    out_item_t bytes_due [$];

    // predicted register and link state
    logic [31:0] cfg_id;
    logic [3:0]  cfg_live_ch;
    logic        cfg_acc;
    logic [15:0] cfg_bind_len;
    logic [15:0] binds_remaining;
    logic [3:0]  hop_col;

    // idle percentages for sender gaps and receiver stalls
    int gap_pct   = 0;
    int stall_pct = 0;
    int s_gap     = 0;
    int m_stall   = 0;

    // run statistics
    int n_errors   = 0;
    int n_packets  = 0;
    int n_bind     = 0;
    int n_starts   = 0;
    int n_ignored  = 0;
    int n_bytes    = 0;
    int n_settings = 0;

    // one line per mismatch, quiet after the first MAX_PRINT
    task automatic report_mismatch(input string what, input longint got, input longint want);
        n_errors++;
        if (n_errors <= MAX_PRINT)
            $display("[%0t] MISMATCH %s: got 0x%0h expected 0x%0h", $time, what, got, want);
    endtask

    // scaled and clamped pulse width in microseconds
    function automatic logic [11:0] pulse_us(input logic signed [15:0] v);
        int w;
        w = (int'(PW_GAIN) * int'(v)) / FULL_SCALE + int'(PW_CENTER);
        if (w < int'(PW_MIN))
            w = int'(PW_MIN);
        else if (w > int'(PW_MAX))
            w = int'(PW_MAX);
        return w[11:0];
    endfunction

    // advance the link state for one request and queue the packet it produces
    function automatic void apply_request(input in_item_t req);
        logic [7:0]         pkt [PKT_LEN];
        logic signed [15:0] chv [NUM_CH];
        logic [11:0]        width;
        logic [7:0]         rf;
        logic [3:0]         offs;
        logic               binding;
        logic               finished;
        out_item_t          res;
        if (req.req_type == REQ_START || req.req_type == REQ_START_BIND) begin
            binds_remaining = (req.req_type == REQ_START_BIND) ? cfg_bind_len : 16'd0;
            hop_col = '0;
            n_starts++;
            return;
        end
        if (req.req_type != REQ_TICK) begin
            n_ignored++;
            return;
        end
        chv = '{req.ch0, req.ch1, req.ch2, req.ch3, req.ch4, req.ch5, req.ch6, req.ch7};
        binding = (binds_remaining != 16'd0);

        // header: type then id, low byte first
        pkt[0] = binding ? TYPE_BIND : TYPE_NORMAL;
        pkt[1] = cfg_id[7:0];
        pkt[2] = cfg_id[15:8];
        pkt[3] = cfg_id[23:16];
        pkt[4] = cfg_id[31:24];

        // eight little-endian widths, dead slots at center
        for (int i = 0; i < NUM_CH; i++) begin
            width = (i < cfg_live_ch) ? pulse_us(chv[i]) : PW_CENTER;
            pkt[5 + 2 * i] = width[7:0];
            pkt[6 + 2 * i] = {4'd0, width[11:8]};
        end

        // accessory flags overlay the width high bytes
        if (cfg_acc) begin
            if (chv[4] > 0) pkt[12] = pkt[12] | ACC_CH4_FLAG;
            if (chv[5] > 0) pkt[10] = pkt[10] | ACC_CH5_FLAG;
            if (chv[6] > 0) pkt[10] = pkt[10] | ACC_CH6_FLAG;
            if (chv[7] > 0) pkt[12] = pkt[12] | ACC_CH7_FLAG;
        end

        // bind countdown or hop selection
        finished = 1'b0;
        if (binding) begin
            rf = BIND_RF;
            binds_remaining = binds_remaining - 16'd1;
            finished = (binds_remaining == 16'd0);
            n_bind++;
        end else begin
            offs = (cfg_id[7:4] > HOP_OFFS_MAX) ? HOP_OFFS_MAX : cfg_id[7:4];
            rf = HOP_TABLE[cfg_id[3:0]][hop_col] - {4'd0, offs};
            hop_col = hop_col + 4'd1;
        end

        for (int i = 0; i < PKT_LEN; i++) begin
            res.data_byte     = pkt[i];
            res.byte_index    = i[4:0];
            res.rf_channel    = rf;
            res.is_bind       = binding;
            res.bind_finished = finished;
            res.last          = (i == PKT_LEN - 1);
            bytes_due.push_back(res);
        end
        n_packets++;
    endfunction

    // compare one received byte with the oldest owed one
    task automatic check_byte(input out_item_t got);
        out_item_t want;
        if (bytes_due.size() == 0) begin
            report_mismatch("byte with no packet owed", got, 0);
            return;
        end
        want = bytes_due.pop_front();
        if (got.data_byte !== want.data_byte)
            report_mismatch($sformatf("pkt %0d byte %0d data_byte", n_packets, want.byte_index),
                            got.data_byte, want.data_byte);
        if (got.byte_index !== want.byte_index)
            report_mismatch("byte_index", got.byte_index, want.byte_index);
        if (got.rf_channel !== want.rf_channel)
            report_mismatch($sformatf("byte %0d rf_channel", want.byte_index),
                            got.rf_channel, want.rf_channel);
        if (got.is_bind !== want.is_bind)
            report_mismatch("is_bind", got.is_bind, want.is_bind);
        if (got.bind_finished !== want.bind_finished)
            report_mismatch("bind_finished", got.bind_finished, want.bind_finished);
        if (got.last !== want.last)
            report_mismatch($sformatf("byte %0d last", want.byte_index), got.last, want.last);
        n_bytes++;
    endtask

    // request driver: predicts on each accepted transfer, then loads the next request
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_gap   <= 0;
        end else begin
            if (s_valid && s_ready)
                apply_request(s_data);
            if (!s_valid || s_ready) begin
                if (s_gap > 0) begin
                    s_gap   <= s_gap - 1;
                    s_valid <= 1'b0;
                end else if (pending_reqs.size() > 0 && $urandom_range(0, 99) < gap_pct) begin
                    s_gap   <= $urandom_range(0, 12);
                    s_valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    s_data  <= pending_reqs.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random backpressure bursts
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            m_stall <= 0;
        end else begin
            if (m_valid && m_ready)
                check_byte(m_data);
            if (m_stall > 0) begin
                m_stall <= m_stall - 1;
                m_ready <= 1'b0;
            end else if ($urandom_range(0, 99) < stall_pct) begin
                m_stall <= $urandom_range(0, 12);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // width mask of each register for readback
    function automatic logic [31:0] reg_mask(input logic [1:0] idx);
        case (idx)
            REG_RADIO_ID:   return 32'hFFFF_FFFF;
            REG_CH_USED:    return 32'h0000_000F;
            REG_ACC_MODE:   return 32'h0000_0001;
            default:        return 32'h0000_FFFF;
        endcase
    endfunction

    // one apb transfer: setup then access until pready
    task automatic reg_access(input logic [1:0] idx, input logic wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // write a register, mirror it in the prediction, read it back
    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] rd;
        reg_access(idx, 1'b1, value, rd);
        case (idx)
            REG_RADIO_ID:   cfg_id       = value;
            REG_CH_USED:    cfg_live_ch  = value[3:0];
            REG_ACC_MODE:   cfg_acc      = value[0];
            default:        cfg_bind_len = value[15:0];
        endcase
        reg_access(idx, 1'b0, 32'd0, rd);
        if ((rd & reg_mask(idx)) !== (value & reg_mask(idx)))
            report_mismatch($sformatf("readback of register %0d", idx),
                            rd & reg_mask(idx), value & reg_mask(idx));
    endtask

    task automatic set_config(input logic [31:0] id, input logic [3:0] live, input logic acc,
                              input logic [15:0] bind_len);
        reg_write(REG_RADIO_ID, id);
        reg_write(REG_CH_USED, {28'd0, live});
        reg_write(REG_ACC_MODE, {31'd0, acc});
        reg_write(REG_BIND_TICKS, {16'd0, bind_len});
        n_settings++;
    endtask

    // wait until every request is sent and every owed byte has arrived
    task automatic wait_drained();
        while (pending_reqs.size() != 0 || s_valid || bytes_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic logic signed [15:0] rand_ch();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom);
            1:       return 16'(int'($urandom_range(0, 25000)) - 12500);
            2:       return 16'(($urandom_range(0, 1) ? 1 : -1) *
                                int'($urandom_range(11990, 12010)));
            default: return 16'(int'($urandom_range(0, 80)) - 40);
        endcase
    endfunction

    function automatic in_item_t rand_item(input logic [1:0] kind);
        in_item_t it;
        it.req_type = kind;
        it.ch0 = rand_ch();
        it.ch1 = rand_ch();
        it.ch2 = rand_ch();
        it.ch3 = rand_ch();
        it.ch4 = rand_ch();
        it.ch5 = rand_ch();
        it.ch6 = rand_ch();
        it.ch7 = rand_ch();
        return it;
    endfunction

    function automatic in_item_t flat_item(input logic [1:0] kind, input logic signed [15:0] v);
        return '{req_type: kind, ch0: v, ch1: v, ch2: v, ch3: v,
                 ch4: v, ch5: v, ch6: v, ch7: v};
    endfunction

    // stimulus sequence
    initial begin
        in_item_t    it;
        int          start_pct;
        int          r;
        logic [31:0] id;
        logic [15:0] bind_len;

        // state after reset
        cfg_id          = RADIO_ID_RST;
        cfg_live_ch     = CH_USED_RST;
        cfg_acc         = ACC_MODE_RST;
        cfg_bind_len    = BIND_TICKS_RST;
        binds_remaining = '0;
        hop_col         = '0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: extremes, clamp and rounding edges, ignored code, long bind cut short
        gap_pct   = 15;
        stall_pct = 10;
        pending_reqs.push_back(flat_item(REQ_TICK, 16'sd0));
        pending_reqs.push_back(flat_item(REQ_TICK, 16'sd32767));
        pending_reqs.push_back(flat_item(REQ_TICK, -16'sd32768));
        pending_reqs.push_back('{req_type: REQ_TICK, ch0: 16'sd12000, ch1: -16'sd12000,
                                 ch2: 16'sd11999, ch3: -16'sd11999, ch4: -16'sd19,
                                 ch5: -16'sd20, ch6: 16'sd19, ch7: 16'sd20});
        pending_reqs.push_back(rand_item(REQ_UNUSED));
        pending_reqs.push_back(rand_item(REQ_START_BIND));
        pending_reqs.push_back(rand_item(REQ_TICK));
        pending_reqs.push_back(rand_item(REQ_TICK));
        pending_reqs.push_back(rand_item(REQ_START));
        pending_reqs.push_back(rand_item(REQ_TICK));
        pending_reqs.push_back(rand_item(REQ_TICK));
        n_settings++;
        wait_drained();

        // all-ones id, no live slots, accessory flags, single bind packet
        set_config(32'hFFFF_FFFF, 4'd0, 1'b1, 16'd1);
        pending_reqs.push_back(flat_item(REQ_TICK, 16'sd1));
        pending_reqs.push_back(flat_item(REQ_TICK, -16'sd1));
        pending_reqs.push_back(rand_item(REQ_START_BIND));
        pending_reqs.push_back(flat_item(REQ_TICK, 16'sd32767));
        pending_reqs.push_back(rand_item(REQ_TICK));
        pending_reqs.push_back(flat_item(REQ_TICK, 16'sd32767));
        wait_drained();

        // zero id, out-of-range slot count, zero bind length turns bind start into normal
        set_config(32'd0, 4'd15, 1'b0, 16'd0);
        pending_reqs.push_back(rand_item(REQ_START_BIND));
        pending_reqs.push_back(rand_item(REQ_TICK));
        pending_reqs.push_back(rand_item(REQ_TICK));
        wait_drained();

        // random phases under random settings; the last one runs without idling
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            r  = $urandom_range(0, 9);
            id = (r == 0) ? 32'd0 : (r == 1) ? 32'hFFFF_FFFF : 32'($urandom);
            if (ph == 0)
                bind_len = 16'hFFFF;
            else if ($urandom_range(0, 3) == 0)
                bind_len = 16'($urandom_range(7, 30));
            else
                bind_len = 16'($urandom_range(0, 6));
            set_config(id, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), bind_len);

            start_pct = (ph == 1) ? 2 : $urandom_range(4, 15);
            gap_pct   = (ph == RAND_PHASES - 1) ? 0 : $urandom_range(0, 30);
            stall_pct = (ph == RAND_PHASES - 1) ? 0 : $urandom_range(0, 30);

            // a start opens every phase so bind and hop sequences get going
            pending_reqs.push_back(rand_item($urandom_range(0, 1) ? REQ_START_BIND : REQ_START));
            for (int k = 1; k < PHASE_ITEMS; k++) begin
                r = $urandom_range(0, 99);
                if (r < start_pct)
                    it = rand_item(REQ_START);
                else if (r < 2 * start_pct)
                    it = rand_item(REQ_START_BIND);
                else if (r < 2 * start_pct + 4)
                    it = rand_item(REQ_UNUSED);
                else
                    it = rand_item(REQ_TICK);
                pending_reqs.push_back(it);
            end
            wait_drained();
        end

        $display("covered %0d packets (%0d bind), %0d starts, %0d ignored requests",
                 n_packets, n_bind, n_starts, n_ignored);
        $display("compared %0d packet bytes over %0d register settings", n_bytes, n_settings);
        if (n_errors == 0 && bytes_due.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // watchdog well beyond the slowest legal run
    initial begin
        #(5_000_000);
        $display("timeout with %0d packet bytes still owed", bytes_due.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
